@@ design/fswr_pkg.sv @@
// package for the floyd sampler: widths, request codes, register indexes
// and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package fswr_pkg;

  localparam int unsigned MAX_POPULATION = 4096;
  localparam int unsigned BITMAP_WORDS   = MAX_POPULATION / 32;
  localparam int unsigned BM_ADDR_W      = $clog2(BITMAP_WORDS);
  localparam int unsigned BIT_W          = 5;
  localparam int unsigned CNT_W          = 13;
  localparam int unsigned IDX_W          = 12;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned OUT_W          = 2 * IDX_W;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [CNT_W-1:0] MAX_POP = CNT_W'(MAX_POPULATION);

  localparam logic [CFG_IDX_W-1:0] REG_POPULATION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  typedef struct packed {
    logic start;
    logic stop;
    logic ld_draw;
    logic rd_i;
    logic mark_r;
    logic mark_i;
    logic emit;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic cand_ok;
    logic draw_ok;
    logic member;
    logic out_free;
    logic clr_last;
  } sts_t;

  // all ones from the top set bit downward
  function automatic logic [CNT_W-1:0] smear(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] m;
    m = x;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/fswr_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module fswr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/fswr_ctrl.sv @@
// controller state machine for the floyd sampler
// depends on fswr_pkg
`default_nettype none

module fswr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          kind_i,
  output logic               in_ready_o,
  input  wire fswr_pkg::sts_t sts_i,
  output fswr_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_READI = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == fswr_pkg::KIND_START) begin
            cmd_o.start = 1'b1;
            state_d     = S_CLEAR;
          end else if (sts_i.running) begin
            if (!sts_i.cand_ok) begin
              cmd_o.stop = 1'b1;
            end else if (sts_i.draw_ok) begin
              cmd_o.ld_draw = 1'b1;
              state_d       = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if (sts_i.member) begin
          cmd_o.rd_i = 1'b1;
          state_d    = S_READI;
        end else begin
          cmd_o.mark_r = 1'b1;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_READI: begin
        cmd_o.mark_i = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/fswr_dp.sv @@
// datapath for the floyd sampler: config registers, run state, draw mask,
// membership bitmap ram and output register
// depends on fswr_pkg and fswr_ram
`default_nettype none

module fswr_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [fswr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [fswr_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  wire logic [fswr_pkg::WORD_W-1:0]         word_i,
  input  wire fswr_pkg::cmd_t                      cmd_i,
  output fswr_pkg::sts_t                           sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [fswr_pkg::OUT_W-1:0]          out_data_o,
  output logic                                     out_last_o
);

  localparam int unsigned CW = fswr_pkg::CNT_W;
  localparam int unsigned AW = fswr_pkg::BM_ADDR_W;
  localparam int unsigned BW = fswr_pkg::BIT_W;
  localparam int unsigned IW = fswr_pkg::IDX_W;

  logic [CW-1:0] pop_q, cnt_q;
  logic [CW-1:0] cand_q, slot_q;
  logic          running_q;
  logic [CW-1:0] r_q, chosen_q;
  logic [AW-1:0] clr_q;
  logic          out_valid_q, out_last_q;
  logic [IW-1:0] out_idx_q, out_slot_q;

  logic [CW-1:0] p_eff, m_eff, cand_inc, mask, r_d, chosen_d;
  logic          fin;
  logic [fswr_pkg::WORD_W-1:0] rdata, wdata, bit_sel;
  logic [AW-1:0] raddr, waddr;
  logic [BW-1:0] mark_bit;
  logic          we;

  // effective population and sample count
  assign p_eff    = (pop_q > fswr_pkg::MAX_POP) ? fswr_pkg::MAX_POP : pop_q;
  assign m_eff    = (cnt_q > p_eff) ? p_eff : cnt_q;
  assign cand_inc = cand_q + CW'(1);
  assign mask     = fswr_pkg::smear(cand_inc);
  assign r_d      = word_i[CW-1:0] & mask;
  assign fin      = (cand_inc >= p_eff);

  assign sts_o.running  = running_q;
  assign sts_o.cand_ok  = (cand_q < p_eff);
  assign sts_o.draw_ok  = (r_d <= cand_q);
  assign sts_o.member   = rdata[r_q[BW-1:0]];
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.clr_last = (clr_q == {AW{1'b1}});

  // bitmap access
  assign raddr    = cmd_i.rd_i ? cand_q[BW +: AW] : r_d[BW +: AW];
  assign chosen_d = cmd_i.mark_i ? cand_q : (cmd_i.mark_r ? r_q : chosen_q);
  assign mark_bit = chosen_d[BW-1:0];
  assign bit_sel  = fswr_pkg::WORD_W'(1) << mark_bit;
  assign we       = cmd_i.clr || cmd_i.mark_r || cmd_i.mark_i;
  assign waddr    = cmd_i.clr ? clr_q : chosen_d[BW +: AW];
  assign wdata    = cmd_i.clr ? '0 : (rdata | bit_sel);

  fswr_ram #(
    .WIDTH (fswr_pkg::WORD_W),
    .DEPTH (fswr_pkg::BITMAP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= fswr_pkg::MAX_POP;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fswr_pkg::REG_POPULATION:   pop_q <= cfg_wdata_i;
        fswr_pkg::REG_SAMPLE_COUNT: cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '0;
      slot_q      <= '0;
      running_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.start) begin
        cand_q    <= p_eff - m_eff;
        slot_q    <= '0;
        running_q <= (m_eff != '0);
      end else if (cmd_i.stop) begin
        running_q <= 1'b0;
      end else if (cmd_i.emit) begin
        cand_q <= cand_inc;
        slot_q <= slot_q + CW'(1);
        if (fin) begin
          running_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_draw) begin
      r_q <= r_d;
    end
    if (cmd_i.mark_r || cmd_i.mark_i) begin
      chosen_q <= chosen_d;
    end
    if (cmd_i.emit) begin
      out_idx_q  <= chosen_d[IW-1:0];
      out_slot_q <= slot_q[IW-1:0];
      out_last_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_slot_q, out_idx_q};
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ design/floyd_sample_without_replacement.sv @@
// top level of the floyd sampler: stream ports, controller and datapath
// depends on fswr_pkg, fswr_ctrl and fswr_dp
`default_nettype none

// Draws sample_count distinct indices from 0..population_size-1 by Floyd's
// method, one 32-bit random word per draw attempt (tuser = 0 starts a run,
// tuser = 1 supplies a word). A word that yields a sample passes through a
// check state, and also a second read state when the drawn index is already
// marked, since each needs a read then a write of the 128 x 32 membership
// bitmap ram through its single read port; a rejected or ignored word is
// consumed in the idle state. A start request runs a clearing pass over the
// bitmap, and the same pass follows reset; no request is taken during it. A
// finished sample waits in an output register, and a new word is taken while
// it waits unless another sample is already waiting behind it.

module floyd_sample_without_replacement (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fswr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fswr_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [fswr_pkg::WORD_W-1:0]       s_axis_tdata,  // random_word
  input  wire logic                              s_axis_tuser,  // kind
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [fswr_pkg::OUT_W-1:0]        m_axis_tdata,  // slot, sample_index
  output logic                                   m_axis_tlast
);

  fswr_pkg::cmd_t cmd;
  fswr_pkg::sts_t sts;

  fswr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fswr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == fswr_pkg::KIND_START)
      |=> !s_axis_tready)
    else $error("start request did not begin the clearing pass");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("sample loaded over a waiting sample");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("loaded sample not presented");

  a_one_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mark_r && cmd.mark_i) && !(cmd.clr && (cmd.mark_r || cmd.mark_i)))
    else $error("conflicting bitmap writes");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ld_draw |=> !s_axis_tready)
    else $error("new request taken during a draw");

endmodule

`default_nettype wire
